>>> hw/rtl/lnm_pkg.sv
// ----------------------------------------------------------------------------
// lnm_pkg
// Shared constants and types of the letterbox nearest-neighbour pixel map.
// ----------------------------------------------------------------------------
package lnm_pkg;

  localparam int MaxSrcW = 512;
  localparam int MaxSrcH = 288;
  localparam int PanelW  = 1024;
  localparam int PanelH  = 600;

  localparam int AddrW      = 5;
  localparam int DataW      = 32;
  localparam int FracW      = 16;
  localparam int SclW       = 27;
  localparam int RecipShift = 26;

  typedef logic [SclW-1:0] lnm_scl_t;

  typedef enum logic [2:0] {
    REG_WINDOW_X  = 3'd0,
    REG_WINDOW_Y  = 3'd1,
    REG_WINDOW_W  = 3'd2,
    REG_WINDOW_H  = 3'd3,
    REG_PICTURE_W = 3'd4,
    REG_PICTURE_H = 3'd5
  } lnm_reg_e;

  typedef struct packed {
    logic        refuse;
    lnm_scl_t    scale;
    lnm_scl_t    recip;
    logic [10:0] out_w;
    logic [9:0]  out_h;
    logic [10:0] out_x;
    logic [10:0] out_y;
    logic [9:0]  pic_w;
    logic [8:0]  pic_h;
  } lnm_geom_t;

  typedef struct packed {
    logic     start;
    lnm_scl_t dividend;
    lnm_scl_t divisor;
  } lnm_div_req_t;

  typedef struct packed {
    logic     done;
    lnm_scl_t quotient;
  } lnm_div_rsp_t;

endpackage

>>> hw/rtl/lnm_if.sv
// ----------------------------------------------------------------------------
// lnm_if
// Valid/ready channels for pixel coordinates in and mapped locations out.
// ----------------------------------------------------------------------------
interface lnm_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] out_row;
  logic [9:0] out_col;

  modport source (output valid, output out_row, output out_col, input ready);
  modport sink   (input valid, input out_row, input out_col, output ready);
endinterface

interface lnm_out_if;
  logic        valid;
  logic        ready;
  logic        inside_res;
  logic [17:0] source_index;
  logic [19:0] dest_index;

  modport source (output valid, output inside_res, output source_index,
                  output dest_index, input ready);
  modport sink   (input valid, input inside_res, input source_index,
                  input dest_index, output ready);
endinterface

>>> hw/rtl/letterbox_nearest_neighbour_map.sv
// six register stages, s1 to s6, between the input and the output port
// throughput: one word per cycle, stalls from the output fill bubbles first
// reset clears the pipeline and loads the register reset values
// after reset and after every register write the setup sequencer runs
// three 27-step divisions plus sizing and centering, input ready held low
// ----------------------------------------------------------------------------
// letterbox_nearest_neighbour_map
// Maps an output pixel of a letterboxed nearest-neighbour scale to its source
// pixel index and panel framebuffer index.
// ----------------------------------------------------------------------------
module letterbox_nearest_neighbour_map #(
  parameter int MAX_SRC_W = lnm_pkg::MaxSrcW,
  parameter int MAX_SRC_H = lnm_pkg::MaxSrcH,
  parameter int PANEL_W   = lnm_pkg::PanelW,
  parameter int PANEL_H   = lnm_pkg::PanelH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  lnm_in_if.sink                    in_i,
  lnm_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lnm_pkg::AddrW-1:0] paddr,
  input  logic [lnm_pkg::DataW-1:0] pwdata,
  output logic [lnm_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  lnm_pkg::lnm_geom_t geom;
  logic               busy;

  lnm_cfg #(
    .MAX_SRC_W(MAX_SRC_W),
    .MAX_SRC_H(MAX_SRC_H)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .geom_o (geom),
    .busy_o (busy)
  );

  lnm_pipe #(
    .PANEL_W(PANEL_W),
    .PANEL_H(PANEL_H)
  ) u_pipe (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .hold_i(busy),
    .geom_i(geom),
    .in_i  (in_i),
    .out_o (out_o)
  );

endmodule

>>> hw/rtl/lnm_div.sv
// ----------------------------------------------------------------------------
// lnm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lnm_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lnm_pkg::lnm_div_req_t req_i,
  output lnm_pkg::lnm_div_rsp_t rsp_o
);

  localparam int W    = lnm_pkg::SclW;
  localparam int CntW = $clog2(W);
  localparam logic [CntW-1:0] Last = CntW'(W - 1);

  logic [W-1:0]    rem_q, quo_q, dvs_q;
  logic [W-1:0]    rem_d, quo_d;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [W:0]      sh, diff;
  logic            ge;

  always_comb begin
    sh    = {rem_q, quo_q[W-1]};
    diff  = sh - {1'b0, dvs_q};
    ge    = sh >= {1'b0, dvs_q};
    rem_d = ge ? diff[W-1:0] : sh[W-1:0];
    quo_d = {quo_q[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == Last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> hw/rtl/lnm_cfg.sv
// ----------------------------------------------------------------------------
// lnm_cfg
// Register file and setup sequencer: derives scale, reciprocal and placement.
// ----------------------------------------------------------------------------
module lnm_cfg #(
  parameter int MAX_SRC_W = lnm_pkg::MaxSrcW,
  parameter int MAX_SRC_H = lnm_pkg::MaxSrcH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lnm_pkg::AddrW-1:0] paddr,
  input  logic [lnm_pkg::DataW-1:0] pwdata,
  output logic [lnm_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output lnm_pkg::lnm_geom_t        geom_o,
  output logic                      busy_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_KICK_X, ST_WAIT_X, ST_KICK_Y, ST_WAIT_Y,
    ST_KICK_R, ST_WAIT_R, ST_SIZE, ST_CENTER
  } state_e;

  localparam lnm_pkg::lnm_scl_t RecipNum = lnm_pkg::lnm_scl_t'(1) << lnm_pkg::RecipShift;
  localparam logic [11:0] MaxW = 12'(MAX_SRC_W);
  localparam logic [11:0] MaxH = 12'(MAX_SRC_H);

  state_e               state_q;
  logic [9:0]           wx_q, wy_q, wh_q, pw_q;
  logic [10:0]          ww_q;
  logic [8:0]           ph_q;
  lnm_pkg::lnm_scl_t    sx_q, scale_q, recip_q;
  logic [10:0]          out_w_q, out_x_q, out_y_q;
  logic [9:0]           out_h_q;
  logic                 refuse_q;
  logic                 wr;
  lnm_pkg::lnm_reg_e    idx;
  lnm_pkg::lnm_div_req_t div_req;
  lnm_pkg::lnm_div_rsp_t div_rsp;
  logic [36:0]          pw_prod, ph_prod;
  logic [10:0]          free_w;
  logic [9:0]           free_h;

  assign wr     = psel && penable && pwrite;
  assign idx    = lnm_pkg::lnm_reg_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wx_q <= '0;
      wy_q <= '0;
      ww_q <= 11'd1024;
      wh_q <= 10'd600;
      pw_q <= 10'd512;
      ph_q <= 9'd288;
    end else if (wr) begin
      unique case (idx)
        lnm_pkg::REG_WINDOW_X:  wx_q <= pwdata[9:0];
        lnm_pkg::REG_WINDOW_Y:  wy_q <= pwdata[9:0];
        lnm_pkg::REG_WINDOW_W:  ww_q <= pwdata[10:0];
        lnm_pkg::REG_WINDOW_H:  wh_q <= pwdata[9:0];
        lnm_pkg::REG_PICTURE_W: pw_q <= pwdata[9:0];
        lnm_pkg::REG_PICTURE_H: ph_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lnm_pkg::REG_WINDOW_X:  prdata = {22'b0, wx_q};
      lnm_pkg::REG_WINDOW_Y:  prdata = {22'b0, wy_q};
      lnm_pkg::REG_WINDOW_W:  prdata = {21'b0, ww_q};
      lnm_pkg::REG_WINDOW_H:  prdata = {22'b0, wh_q};
      lnm_pkg::REG_PICTURE_W: prdata = {22'b0, pw_q};
      lnm_pkg::REG_PICTURE_H: prdata = {23'b0, ph_q};
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    div_req.start    = (state_q == ST_KICK_X) || (state_q == ST_KICK_Y) ||
                       (state_q == ST_KICK_R);
    div_req.dividend = {ww_q, 16'b0};
    div_req.divisor  = {17'b0, pw_q};
    unique case (state_q)
      ST_KICK_Y: begin
        div_req.dividend = {1'b0, wh_q, 16'b0};
        div_req.divisor  = {18'b0, ph_q};
      end
      ST_KICK_R: begin
        div_req.dividend = RecipNum;
        div_req.divisor  = scale_q;
      end
      default: ;
    endcase
  end

  lnm_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign pw_prod = 37'(pw_q) * 37'(scale_q);
  assign ph_prod = 37'(ph_q) * 37'(scale_q);
  assign free_w  = ww_q - out_w_q;
  assign free_h  = wh_q - out_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_KICK_X;
      sx_q     <= '0;
      scale_q  <= '0;
      recip_q  <= '0;
      out_w_q  <= '0;
      out_h_q  <= '0;
      out_x_q  <= '0;
      out_y_q  <= '0;
      refuse_q <= 1'b1;
    end else if (wr) begin
      state_q <= ST_KICK_X;
    end else begin
      unique case (state_q)
        ST_IDLE:   state_q <= ST_IDLE;
        ST_KICK_X: state_q <= ST_WAIT_X;
        ST_WAIT_X: begin
          if (div_rsp.done) begin
            sx_q    <= div_rsp.quotient;
            state_q <= ST_KICK_Y;
          end
        end
        ST_KICK_Y: state_q <= ST_WAIT_Y;
        ST_WAIT_Y: begin
          if (div_rsp.done) begin
            scale_q <= (div_rsp.quotient < sx_q) ? div_rsp.quotient : sx_q;
            state_q <= ST_KICK_R;
          end
        end
        ST_KICK_R: state_q <= ST_WAIT_R;
        ST_WAIT_R: begin
          if (div_rsp.done) begin
            recip_q <= div_rsp.quotient;
            state_q <= ST_SIZE;
          end
        end
        ST_SIZE: begin
          out_w_q <= pw_prod[26:16];
          out_h_q <= ph_prod[25:16];
          state_q <= ST_CENTER;
        end
        ST_CENTER: begin
          out_x_q  <= {1'b0, wx_q} + {1'b0, free_w[10:1]};
          out_y_q  <= {1'b0, wy_q} + {2'b0, free_h[9:1]};
          refuse_q <= (pw_q == '0) || (ph_q == '0) || ({2'b0, pw_q} > MaxW) ||
                      ({3'b0, ph_q} > MaxH) || (scale_q == '0);
          state_q  <= ST_IDLE;
        end
        default: state_q <= ST_KICK_X;
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    geom_o.refuse = refuse_q;
    geom_o.scale  = scale_q;
    geom_o.recip  = recip_q;
    geom_o.out_w  = out_w_q;
    geom_o.out_h  = out_h_q;
    geom_o.out_x  = out_x_q;
    geom_o.out_y  = out_y_q;
    geom_o.pic_w  = pw_q;
    geom_o.pic_h  = ph_q;
  end

endmodule

>>> hw/rtl/lnm_pipe.sv
// ----------------------------------------------------------------------------
// lnm_pipe
// Six-stage pixel map: reciprocal divide with correction, then index build.
// ----------------------------------------------------------------------------
module lnm_pipe #(
  parameter int PANEL_W = lnm_pkg::PanelW,
  parameter int PANEL_H = lnm_pkg::PanelH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               hold_i,
  input  lnm_pkg::lnm_geom_t geom_i,
  lnm_in_if.sink             in_i,
  lnm_out_if.source          out_o
);

  localparam int SW = lnm_pkg::SclW;
  localparam int Sh = lnm_pkg::RecipShift - lnm_pkg::FracW;
  localparam logic [12:0] PanW = 13'(PANEL_W);
  localparam logic [12:0] PanH = 13'(PANEL_H);

  logic [6:1] v_q, en;
  logic       acc;

  logic [9:0]    s1_row_q, s1_col_q, s2_row_q, s2_col_q, s3_row_q, s3_col_q;
  logic [11:0]   s1_drow_q, s1_dcol_q, s2_drow_q, s2_dcol_q, s3_drow_q, s3_dcol_q;
  logic [11:0]   s4_drow_q, s4_dcol_q, s5_dcol_q;
  logic          s1_ok_q, s2_ok_q, s3_ok_q, s4_ok_q, s5_ok_q;
  logic [SW-1:0] s2_q0r_q, s2_q0c_q, s3_q0r_q, s3_q0c_q, s3_mr_q, s3_mc_q;
  logic [SW-1:0] s4_qr_q, s4_qc_q;
  logic [17:0]   s5_sprod_q, s5_sc_q;
  logic [19:0]   s5_dprod_q;
  logic          s6_in_q;
  logic [17:0]   s6_src_q;
  logic [19:0]   s6_dst_q;

  logic [36:0]   p_row, p_col;
  logic [SW-1:0] r_row, r_col;

  always_comb begin
    en[6] = !v_q[6] || out_o.ready;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[1] && !hold_i;
  assign acc        = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= acc;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign p_row = 37'(s1_row_q) * 37'(geom_i.recip);
  assign p_col = 37'(s1_col_q) * 37'(geom_i.recip);
  assign r_row = {1'b0, s3_row_q, {lnm_pkg::FracW{1'b0}}} - s3_mr_q;
  assign r_col = {1'b0, s3_col_q, {lnm_pkg::FracW{1'b0}}} - s3_mc_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_row_q  <= in_i.out_row;
      s1_col_q  <= in_i.out_col;
      s1_ok_q   <= !geom_i.refuse && (in_i.out_row < geom_i.out_h) &&
                   ({1'b0, in_i.out_col} < geom_i.out_w);
      s1_drow_q <= {1'b0, geom_i.out_y} + {2'b0, in_i.out_row};
      s1_dcol_q <= {1'b0, geom_i.out_x} + {2'b0, in_i.out_col};
    end
    if (en[2]) begin
      s2_q0r_q  <= p_row[Sh +: SW];
      s2_q0c_q  <= p_col[Sh +: SW];
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_ok_q   <= s1_ok_q && ({1'b0, s1_drow_q} < PanH) && ({1'b0, s1_dcol_q} < PanW);
      s2_drow_q <= s1_drow_q;
      s2_dcol_q <= s1_dcol_q;
    end
    if (en[3]) begin
      s3_mr_q   <= s2_q0r_q * geom_i.scale;
      s3_mc_q   <= s2_q0c_q * geom_i.scale;
      s3_q0r_q  <= s2_q0r_q;
      s3_q0c_q  <= s2_q0c_q;
      s3_row_q  <= s2_row_q;
      s3_col_q  <= s2_col_q;
      s3_ok_q   <= s2_ok_q;
      s3_drow_q <= s2_drow_q;
      s3_dcol_q <= s2_dcol_q;
    end
    if (en[4]) begin
      s4_qr_q   <= s3_q0r_q + SW'(r_row >= geom_i.scale);
      s4_qc_q   <= s3_q0c_q + SW'(r_col >= geom_i.scale);
      s4_ok_q   <= s3_ok_q;
      s4_drow_q <= s3_drow_q;
      s4_dcol_q <= s3_dcol_q;
    end
    if (en[5]) begin
      s5_ok_q    <= s4_ok_q && (s4_qr_q < {18'b0, geom_i.pic_h});
      s5_sc_q    <= (s4_qc_q < {17'b0, geom_i.pic_w}) ? s4_qc_q[17:0] : '0;
      s5_sprod_q <= s4_qr_q[17:0] * {8'b0, geom_i.pic_w};
      s5_dprod_q <= 20'(s4_drow_q * PANEL_W);
      s5_dcol_q  <= s4_dcol_q;
    end
    if (en[6]) begin
      s6_in_q  <= s5_ok_q;
      s6_src_q <= s5_ok_q ? s5_sprod_q + s5_sc_q : '0;
      s6_dst_q <= s5_ok_q ? s5_dprod_q + {8'b0, s5_dcol_q} : '0;
    end
  end

  assign out_o.valid        = v_q[6];
  assign out_o.inside_res   = s6_in_q;
  assign out_o.source_index = s6_src_q;
  assign out_o.dest_index   = s6_dst_q;

endmodule

>>> hw/rtl/lnm_checker.sv
// ----------------------------------------------------------------------------
// lnm_checker
// Port-level checks of the pixel map, bound to the top level.
// ----------------------------------------------------------------------------
module lnm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        inside_res_i,
  input logic [17:0] source_index_i,
  input logic [19:0] dest_index_i,
  input logic        psel_i,
  input logic        penable_i,
  input logic        pwrite_i,
  input logic        pready_i
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(inside_res_i) &&
    $stable(source_index_i) && $stable(dest_index_i))
    else $error("stalled output word changed");

  // undrawn pixels carry zero indexes
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !inside_res_i |-> source_index_i == '0 && dest_index_i == '0)
    else $error("undrawn pixel with nonzero index");

  // a register write starts the setup pass
  a_setup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i |=> !in_ready_i)
    else $error("input ready during setup");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("pready low");

endmodule

bind letterbox_nearest_neighbour_map lnm_checker u_lnm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .inside_res_i  (out_o.inside_res),
  .source_index_i(out_o.source_index),
  .dest_index_i  (out_o.dest_index),
  .psel_i        (psel),
  .penable_i     (penable),
  .pwrite_i      (pwrite),
  .pready_i      (pready)
);
